FILE: rtl/text_line_sorter_top_defines.svh
// ----------------------------------------------------------------------------
// text_line_sorter_top_defines
// Assertion macros for the text line sorter.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_SORTER_TOP_DEFINES_SVH
`define TEXT_LINE_SORTER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TLS_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TLS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tls_pkg.sv
// ----------------------------------------------------------------------------
// tls_pkg
// Shared constants and types of the text line sorter.
// ----------------------------------------------------------------------------
package tls_pkg;

  localparam int LINES    = 256;
  localparam int LINE_LEN = 128;
  localparam int IDX_W    = $clog2(LINES);
  localparam int COL_W    = $clog2(LINE_LEN);
  localparam int CNT_W    = IDX_W + 1;
  localparam int ADDR_W   = IDX_W + COL_W;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_END    = 2'd1;
  localparam logic [1:0] OP_SORT   = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_OVF = 2'd1;
  localparam logic [1:0] STAT_BAD = 2'd2;

  localparam logic [1:0] REG_COLUMN_START   = 2'd0;
  localparam logic [1:0] REG_CASE_SENSITIVE = 2'd1;
  localparam logic [1:0] REG_NUMERIC_KEYS   = 2'd2;

  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'd32;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef struct packed {
    logic [7:0] column_start;
    logic       case_sensitive;
    logic       numeric_keys;
  } cfg_t;

  typedef struct packed {
    logic done;
    logic lt;
    logic gt;
  } cmp_res_t;

endpackage

FILE: rtl/tls_cmp.sv
// ----------------------------------------------------------------------------
// tls_cmp
// Shared key compare unit: walks two lines of line memory byte by byte.
// ----------------------------------------------------------------------------
module tls_cmp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tls_pkg::IDX_W-1:0]     a_line,
  input  logic [tls_pkg::IDX_W-1:0]     b_line,
  input  tls_pkg::cfg_t                 cfg,
  input  logic [tls_pkg::COL_W-1:0]     len_data,
  input  logic [7:0]                    store_data,
  output logic [tls_pkg::IDX_W-1:0]     len_addr,
  output logic [tls_pkg::ADDR_W-1:0]    store_addr,
  output tls_pkg::cmp_res_t             res
);

  localparam logic [3:0] C_IDLE = 4'd0;
  localparam logic [3:0] C_LA   = 4'd1;
  localparam logic [3:0] C_LB   = 4'd2;
  localparam logic [3:0] C_LBD  = 4'd3;
  localparam logic [3:0] C_TRA  = 4'd4;
  localparam logic [3:0] C_TRB  = 4'd5;
  localparam logic [3:0] C_TRC  = 4'd6;
  localparam logic [3:0] C_NRD  = 4'd7;
  localparam logic [3:0] C_NUSE = 4'd8;
  localparam logic [3:0] C_NEND = 4'd9;

  logic [3:0]                  state;
  logic [tls_pkg::IDX_W-1:0]   a_reg, b_reg;
  logic [tls_pkg::COL_W-1:0]   sa, sb, la, lb, k;
  logic [7:0]                  ca;
  logic [31:0]                 num, na;
  logic                        neg, phase, which;
  logic [tls_pkg::COL_W-1:0]   key_start, key_len, cur_len;
  logic signed [7:0]           fa, fb;
  logic [31:0]                 num_val;
  logic [tls_pkg::COL_W-1:0]   col_a, col_b;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic exact);
    logic [7:0] r;
    r = c;
    if (!exact && c >= tls_pkg::CH_UP_A && c <= tls_pkg::CH_UP_Z) begin
      r = c + tls_pkg::CASE_OFS;
    end
    return r;
  endfunction

  // key window of the line whose length is on len_data
  always_comb begin
    key_start = '0;
    key_len   = len_data;
    if (cfg.column_start != 8'd0) begin
      if (cfg.column_start <= {1'b0, len_data}) begin
        key_start = tls_pkg::COL_W'(cfg.column_start - 8'd1);
        key_len   = len_data - key_start;
      end else begin
        key_len = '0;
      end
    end
  end

  assign col_a    = sa + k;
  assign col_b    = sb + k;
  assign len_addr = (state == C_LA) ? a_reg : b_reg;
  assign cur_len  = which ? lb : la;
  assign fa       = $signed(fold(ca, cfg.case_sensitive));
  assign fb       = $signed(fold(store_data, cfg.case_sensitive));
  assign num_val  = (neg ? (32'd0 - num) : num) ^ 32'h8000_0000;

  always_comb begin
    if (state == C_TRB || (state == C_NRD && which)) begin
      store_addr = {b_reg, col_b};
    end else begin
      store_addr = {a_reg, col_a};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      res   <= '0;
    end else begin
      // done pulses for one cycle; the unit is idle while it is high
      if (res.done) res.done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            a_reg <= a_line;
            b_reg <= b_line;
            state <= C_LA;
          end
        end
        C_LA: state <= C_LB;
        C_LB: begin
          sa    <= key_start;
          la    <= key_len;
          state <= C_LBD;
        end
        C_LBD: begin
          sb    <= key_start;
          lb    <= key_len;
          k     <= '0;
          num   <= '0;
          neg   <= 1'b0;
          phase <= 1'b0;
          which <= 1'b0;
          state <= cfg.numeric_keys ? C_NRD : C_TRA;
        end
        C_TRA: begin
          if (k < la && k < lb) begin
            state <= C_TRB;
          end else begin
            res   <= '{done: 1'b1, lt: (la < lb), gt: (la > lb)};
            state <= C_IDLE;
          end
        end
        C_TRB: begin
          ca    <= store_data;
          state <= C_TRC;
        end
        C_TRC: begin
          if (fa != fb) begin
            res   <= '{done: 1'b1, lt: (fa < fb), gt: (fa > fb)};
            state <= C_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= C_TRA;
          end
        end
        C_NRD: state <= (k < cur_len) ? C_NUSE : C_NEND;
        C_NUSE: begin
          state <= C_NRD;
          if (!phase) begin
            if (store_data == tls_pkg::CH_SPACE || store_data == tls_pkg::CH_TAB) begin
              k <= k + 1'b1;
            end else if (store_data == tls_pkg::CH_MINUS) begin
              neg   <= 1'b1;
              k     <= k + 1'b1;
              phase <= 1'b1;
            end else if (store_data == tls_pkg::CH_PLUS) begin
              k     <= k + 1'b1;
              phase <= 1'b1;
            end else begin
              phase <= 1'b1;  // revisit this byte as a digit
            end
          end else if (store_data >= tls_pkg::CH_0 && store_data <= tls_pkg::CH_9) begin
            num <= (num << 3) + (num << 1) + {24'd0, store_data - tls_pkg::CH_0};
            k   <= k + 1'b1;
          end else begin
            state <= C_NEND;
          end
        end
        C_NEND: begin
          if (!which) begin
            na    <= num_val;
            which <= 1'b1;
            k     <= '0;
            num   <= '0;
            neg   <= 1'b0;
            phase <= 1'b0;
            state <= C_NRD;
          end else begin
            res   <= '{done: 1'b1, lt: (na < num_val), gt: (na > num_val)};
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/text_line_sorter_top.sv
// ----------------------------------------------------------------------------
// text_line_sorter_top
// Line loader, quicksort sequencer and sorted read-out of the line sorter.
// ----------------------------------------------------------------------------
// An append or end-line item goes straight to the output register; a read
// first fetches the order entry, then the line length and byte. The output
// register lets the next item in while a result waits. A sort item seeds
// the order table with one entry per loaded line, then runs Hoare quicksort
// with the middle pivot; each key compare goes through the single compare
// unit, which reads one key byte at a time, since the line memory has one
// read port. Line, length, order and stack memories need no clearing pass
// after reset.
`include "text_line_sorter_top_defines.svh"

module text_line_sorter_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   operation,
  input  logic [7:0]                   char_in,
  input  logic [7:0]                   rank,
  input  logic [6:0]                   column,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [7:0]                   char_out,
  output logic [6:0]                   line_length,
  output logic [8:0]                   line_count
);

  localparam int IW = tls_pkg::IDX_W;
  localparam int CW = tls_pkg::COL_W;
  localparam int NW = tls_pkg::CNT_W;
  localparam int AW = tls_pkg::ADDR_W;
  localparam int DEPTH = tls_pkg::LINES;
  localparam int STORE_DEPTH = tls_pkg::LINES * tls_pkg::LINE_LEN;
  localparam logic signed [IW+1:0] ONE_S = (IW+2)'(1);

  localparam logic [4:0] T_IDLE  = 5'd0;
  localparam logic [4:0] T_INIT  = 5'd1;
  localparam logic [4:0] T_POP   = 5'd2;
  localparam logic [4:0] T_POPD  = 5'd3;
  localparam logic [4:0] T_PIV   = 5'd4;
  localparam logic [4:0] T_LOOP  = 5'd5;
  localparam logic [4:0] T_IW    = 5'd6;
  localparam logic [4:0] T_IWD   = 5'd7;
  localparam logic [4:0] T_IWC   = 5'd8;
  localparam logic [4:0] T_JW    = 5'd9;
  localparam logic [4:0] T_JWD   = 5'd10;
  localparam logic [4:0] T_JWC   = 5'd11;
  localparam logic [4:0] T_SWAP1 = 5'd12;
  localparam logic [4:0] T_SWAP2 = 5'd13;
  localparam logic [4:0] T_PUSH1 = 5'd14;
  localparam logic [4:0] T_PUSH2 = 5'd15;
  localparam logic [4:0] T_RD1   = 5'd16;
  localparam logic [4:0] T_RD2   = 5'd17;
  localparam logic [4:0] T_RD3   = 5'd18;
  localparam logic [4:0] T_DONE  = 5'd19;

  // memories
  logic [7:0]      line_store   [STORE_DEPTH];
  logic [CW-1:0]   line_lengths [DEPTH];
  logic [IW-1:0]   order_table  [DEPTH];
  logic [2*IW-1:0] range_stack  [DEPTH];

  logic [4:0]       state;
  tls_pkg::cfg_t    cfg;
  logic [NW-1:0]    lines_loaded;
  logic [CW-1:0]    fill_column, runlen, runlen_new;
  logic             zseen, zseen_new;
  logic             overflow_flag, sorted_flag;
  logic [NW-1:0]    sp, k;
  logic [IW-1:0]    lo, hi, piv, ai, aj;
  logic signed [IW+1:0] i, j, lo_s, hi_s;
  logic [CW-1:0]    in_col;
  logic [IW-1:0]    in_rank;
  logic             res_bad;
  logic [7:0]       res_char;
  logic [CW-1:0]    res_len;
  logic             accept, full, close_line;
  logic             push_lo, push_hi;

  logic             st_we;
  logic [AW-1:0]    st_waddr, st_raddr;
  logic [7:0]       st_rdata;
  logic [IW-1:0]    ln_raddr;
  logic [CW-1:0]    ln_rdata;
  logic             ord_we;
  logic [IW-1:0]    ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic             stk_we;
  logic [IW-1:0]    stk_waddr, stk_raddr;
  logic [2*IW-1:0]  stk_wdata, stk_rdata;
  logic [IW:0]      mid_sum;

  logic             cmp_start;
  logic [IW-1:0]    cmp_len_addr;
  logic [AW-1:0]    cmp_store_addr;
  tls_pkg::cmp_res_t cmp_res;

  assign pready   = 1'b1;
  assign in_ready = (state == T_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (lines_loaded >= NW'(DEPTH));
  assign lo_s     = $signed({2'b00, lo});
  assign hi_s     = $signed({2'b00, hi});
  assign push_lo  = (lo_s < j) && (sp < NW'(DEPTH));
  assign push_hi  = (i < hi_s) && (sp < NW'(DEPTH));
  assign mid_sum  = {1'b0, stk_rdata[2*IW-1:IW]} + {1'b0, stk_rdata[IW-1:0]};

  always_comb begin
    case (paddr[3:2])
      tls_pkg::REG_COLUMN_START:   prdata = {24'd0, cfg.column_start};
      tls_pkg::REG_CASE_SENSITIVE: prdata = {31'd0, cfg.case_sensitive};
      tls_pkg::REG_NUMERIC_KEYS:   prdata = {31'd0, cfg.numeric_keys};
      default:                     prdata = 32'd0;
    endcase
  end

  // loader: byte write and line close
  always_comb begin
    st_we      = 1'b0;
    close_line = 1'b0;
    runlen_new = runlen;
    zseen_new  = zseen;
    st_waddr   = {lines_loaded[IW-1:0], fill_column};
    if (accept && !full) begin
      case (operation)
        tls_pkg::OP_APPEND, tls_pkg::OP_END: begin
          if (operation == tls_pkg::OP_END || char_in == tls_pkg::CH_LF) begin
            close_line = 1'b1;
          end else begin
            st_we = 1'b1;
            if (!zseen && char_in != 8'd0) runlen_new = runlen + 1'b1;
            if (char_in == 8'd0) zseen_new = 1'b1;
            if (fill_column >= CW'(tls_pkg::LINE_LEN - 2)) close_line = 1'b1;
          end
        end
        tls_pkg::OP_SORT: close_line = (fill_column != '0);
        default: close_line = 1'b0;
      endcase
    end
  end

  // order table and range stack ports
  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = k[IW-1:0];
    ord_wdata = k[IW-1:0];
    stk_we    = 1'b0;
    stk_waddr = sp[IW-1:0];
    stk_wdata = {lo, j[IW-1:0]};
    case (state)
      T_INIT: begin
        if (k < lines_loaded) begin
          ord_we = 1'b1;
        end else if (lines_loaded > NW'(1)) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = {{IW{1'b0}}, IW'(lines_loaded - 1'b1)};
        end
      end
      T_SWAP1: begin
        ord_we    = 1'b1;
        ord_waddr = i[IW-1:0];
        ord_wdata = aj;
      end
      T_SWAP2: begin
        ord_we    = 1'b1;
        ord_waddr = j[IW-1:0];
        ord_wdata = ai;
      end
      T_PUSH1: stk_we = push_lo;
      T_PUSH2: begin
        stk_we    = push_hi;
        stk_wdata = {i[IW-1:0], hi};
      end
      default: ord_we = 1'b0;
    endcase
  end

  always_comb begin
    case (state)
      T_POPD:  ord_raddr = mid_sum[IW:1];
      T_IW:    ord_raddr = i[IW-1:0];
      T_JW:    ord_raddr = j[IW-1:0];
      default: ord_raddr = in_rank;
    endcase
  end

  assign stk_raddr = IW'(sp - 1'b1);
  assign ln_raddr  = (state == T_RD2) ? ord_rdata : cmp_len_addr;
  assign st_raddr  = (state == T_RD2) ? {ord_rdata, in_col} : cmp_store_addr;
  assign cmp_start = (state == T_IWD) || (state == T_JWD);

  always_ff @(posedge clk) begin
    if (st_we) line_store[st_waddr] <= char_in;
    st_rdata <= line_store[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (close_line) line_lengths[lines_loaded[IW-1:0]] <= runlen_new;
    ln_rdata <= line_lengths[ln_raddr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) order_table[ord_waddr] <= ord_wdata;
    ord_rdata <= order_table[ord_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) range_stack[stk_waddr] <= stk_wdata;
    stk_rdata <= range_stack[stk_raddr];
  end

  tls_cmp u_cmp (
    .clk        (clk),
    .rst        (rst),
    .start      (cmp_start),
    .a_line     (ord_rdata),
    .b_line     (piv),
    .cfg        (cfg),
    .len_data   (ln_rdata),
    .store_data (st_rdata),
    .len_addr   (cmp_len_addr),
    .store_addr (cmp_store_addr),
    .res        (cmp_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      cfg           <= '0;
      lines_loaded  <= '0;
      fill_column   <= '0;
      runlen        <= '0;
      zseen         <= 1'b0;
      overflow_flag <= 1'b0;
      sorted_flag   <= 1'b0;
      sp            <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          tls_pkg::REG_COLUMN_START:   cfg.column_start   <= pwdata[7:0];
          tls_pkg::REG_CASE_SENSITIVE: cfg.case_sensitive <= pwdata[0];
          tls_pkg::REG_NUMERIC_KEYS:   cfg.numeric_keys   <= pwdata[0];
          default: cfg <= cfg;
        endcase
      end

      if (close_line) begin
        lines_loaded <= lines_loaded + 1'b1;
        fill_column  <= '0;
        runlen       <= '0;
        zseen        <= 1'b0;
      end else if (st_we) begin
        fill_column <= fill_column + 1'b1;
        runlen      <= runlen_new;
        zseen       <= zseen_new;
      end

      // T_DONE reloads the output register itself when a transfer frees it
      if (out_valid && out_ready && state != T_DONE) out_valid <= 1'b0;

      case (state)
        T_IDLE: begin
          if (accept) begin
            in_col   <= column;
            in_rank  <= rank;
            res_bad  <= 1'b0;
            res_char <= 8'd0;
            res_len  <= '0;
            case (operation)
              tls_pkg::OP_APPEND, tls_pkg::OP_END: begin
                sorted_flag <= 1'b0;
                if (full) overflow_flag <= 1'b1;
                state <= T_DONE;
              end
              tls_pkg::OP_SORT: begin
                k     <= '0;
                state <= T_INIT;
              end
              tls_pkg::OP_READ: begin
                if (!sorted_flag || {1'b0, rank} >= lines_loaded) begin
                  res_bad <= 1'b1;
                  state   <= T_DONE;
                end else begin
                  state <= T_RD1;
                end
              end
              default: state <= T_DONE;
            endcase
          end
        end
        T_INIT: begin
          if (k < lines_loaded) begin
            k <= k + 1'b1;
          end else begin
            sp    <= (lines_loaded > NW'(1)) ? NW'(1) : NW'(0);
            state <= T_POP;
          end
        end
        T_POP: begin
          if (sp == '0) begin
            sorted_flag <= 1'b1;
            state       <= T_DONE;
          end else begin
            sp    <= sp - 1'b1;
            state <= T_POPD;
          end
        end
        T_POPD: begin
          lo    <= stk_rdata[2*IW-1:IW];
          hi    <= stk_rdata[IW-1:0];
          i     <= $signed({2'b00, stk_rdata[2*IW-1:IW]});
          j     <= $signed({2'b00, stk_rdata[IW-1:0]});
          state <= (stk_rdata[2*IW-1:IW] >= stk_rdata[IW-1:0]) ? T_POP : T_PIV;
        end
        T_PIV: begin
          piv   <= ord_rdata;
          state <= T_LOOP;
        end
        T_LOOP: state <= (i <= j) ? T_IW : T_PUSH1;
        T_IW:   state <= (i <= hi_s) ? T_IWD : T_JW;
        T_IWD: begin
          ai    <= ord_rdata;
          state <= T_IWC;
        end
        T_IWC: begin
          if (cmp_res.done) begin
            if (cmp_res.lt) begin
              i     <= i + ONE_S;
              state <= T_IW;
            end else begin
              state <= T_JW;
            end
          end
        end
        T_JW: begin
          if (j >= lo_s) state <= T_JWD;
          else state <= (i <= j) ? T_SWAP1 : T_PUSH1;
        end
        T_JWD: begin
          aj    <= ord_rdata;
          state <= T_JWC;
        end
        T_JWC: begin
          if (cmp_res.done) begin
            if (cmp_res.gt) begin
              j     <= j - ONE_S;
              state <= T_JW;
            end else begin
              state <= (i <= j) ? T_SWAP1 : T_PUSH1;
            end
          end
        end
        T_SWAP1: state <= T_SWAP2;
        T_SWAP2: begin
          i     <= i + ONE_S;
          j     <= j - ONE_S;
          state <= T_LOOP;
        end
        T_PUSH1: begin
          if (push_lo) sp <= sp + 1'b1;
          state <= T_PUSH2;
        end
        T_PUSH2: begin
          if (push_hi) sp <= sp + 1'b1;
          state <= T_POP;
        end
        T_RD1: state <= T_RD2;
        T_RD2: state <= T_RD3;
        T_RD3: begin
          res_len  <= ln_rdata;
          res_char <= (in_col < ln_rdata) ? st_rdata : 8'd0;
          state    <= T_DONE;
        end
        T_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_bad ? tls_pkg::STAT_BAD :
                           (overflow_flag ? tls_pkg::STAT_OVF : tls_pkg::STAT_OK);
            char_out    <= res_char;
            line_length <= res_len;
            line_count  <= lines_loaded;
            state       <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  `TLS_CHECK_NEXT(a_busy_after_transfer, accept, !in_ready, "accepted item did not make block busy")
  `TLS_CHECK_NEXT(a_overflow_sticky, overflow_flag, overflow_flag, "overflow flag dropped")
  `TLS_CHECK(a_fill_needs_room, fill_column != '0, !full, "partial line with line table full")
  `TLS_CHECK(a_cmp_one_way, cmp_res.done, !(cmp_res.lt && cmp_res.gt), "compare both lt and gt")

endmodule

FILE: tb/text_line_sorter_top_tb.sv
// ----------------------------------------------------------------------------
// text_line_sorter_top_tb
// Self-checking bench for the text line sorter: loads lines, sorts them under
// several key settings and reads them back, checking each result transfer
// against an in-bench model of the loader, the quicksort and the read-out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_line_sorter_top_tb;

  localparam int LIMIT = 6_000_000;
  localparam int LINES = tls_pkg::LINES;
  localparam int LINE_LEN = tls_pkg::LINE_LEN;

  typedef struct {
    logic [1:0] st;
    logic [7:0] ch;
    logic [6:0] len;
    logic [8:0] cnt;
  } sorter_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = tls_pkg::OP_APPEND;
  logic [7:0]  char_in = '0;
  logic [7:0]  rank = '0;
  logic [6:0]  column = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  char_out;
  logic [6:0]  line_length;
  logic [8:0]  line_count;

  text_line_sorter_top DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // sorter model state
  byte unsigned   text_mem [LINES*LINE_LEN];
  int             len_mem [LINES];
  int             order_mem [LINES];
  int             span_lo [LINES];
  int             span_hi [LINES];
  int             loaded, fill_col;
  bit             ovf_seen, is_sorted;
  tls_pkg::cfg_t  cfg;

  sorter_result_t expected_q [$];
  int             n_err;
  int             cyc;
  int             tx_pct, rx_pct;
  int             hold_req;
  int             hold_cnt;

  function automatic logic [1:0] any_op();
    return 2'($urandom);
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [6:0] any_col();
    return 7'($urandom);
  endfunction

  function automatic void close_line();
    int n;
    n = 0;
    while (n < fill_col && text_mem[loaded*LINE_LEN + n] != 0) n++;
    len_mem[loaded] = n;
    loaded++;
    fill_col = 0;
  endfunction

  function automatic void key_span(input int ln, output int st, output int kl);
    int l;
    l = len_mem[ln];
    st = ln * LINE_LEN;
    kl = l;
    if (cfg.column_start > 0) begin
      if (cfg.column_start <= l) begin
        st += cfg.column_start - 1;
        kl = l - (cfg.column_start - 1);
      end else begin
        kl = 0;
      end
    end
  endfunction

  function automatic int folded(input byte unsigned c);
    byte s;
    if (!cfg.case_sensitive && c >= tls_pkg::CH_UP_A && c <= tls_pkg::CH_UP_Z)
      c = c + tls_pkg::CASE_OFS;
    s = c;
    return s;
  endfunction

  // sign bit flipped so that unsigned compare gives signed order
  function automatic logic [31:0] parsed_number(input int p, input int kl);
    int          k;
    logic [31:0] n;
    bit          neg;
    k = 0;
    n = '0;
    neg = 0;
    while (k < kl && (text_mem[p+k] == tls_pkg::CH_SPACE || text_mem[p+k] == tls_pkg::CH_TAB))
      k++;
    if (k < kl && text_mem[p+k] == tls_pkg::CH_MINUS) begin
      neg = 1;
      k++;
    end else if (k < kl && text_mem[p+k] == tls_pkg::CH_PLUS) begin
      k++;
    end
    while (k < kl && text_mem[p+k] >= tls_pkg::CH_0 && text_mem[p+k] <= tls_pkg::CH_9) begin
      n = n * 32'd10 + 32'(text_mem[p+k] - tls_pkg::CH_0);
      k++;
    end
    if (neg) n = -n;
    return n ^ 32'h8000_0000;
  endfunction

  function automatic int line_order(input int a, input int b);
    int          pa, la, pb, lb, ca, cb;
    logic [31:0] na, nb;
    key_span(a, pa, la);
    key_span(b, pb, lb);
    if (cfg.numeric_keys) begin
      na = parsed_number(pa, la);
      nb = parsed_number(pb, lb);
      return (na < nb) ? -1 : (na > nb) ? 1 : 0;
    end
    for (int k = 0; k < la && k < lb; k++) begin
      ca = folded(text_mem[pa+k]);
      cb = folded(text_mem[pb+k]);
      if (ca < cb) return -1;
      if (ca > cb) return 1;
    end
    return (la > lb) ? 1 : (lb > la) ? -1 : 0;
  endfunction

  function automatic void quicksort_lines();
    int sp, lo, hi, i, j, piv, t;
    sp = 0;
    for (int k = 0; k < loaded; k++) order_mem[k] = k;
    if (loaded > 1) begin
      span_lo[0] = 0;
      span_hi[0] = loaded - 1;
      sp = 1;
    end
    while (sp > 0) begin
      sp--;
      lo = span_lo[sp];
      hi = span_hi[sp];
      if (lo < hi) begin
        piv = order_mem[(lo + hi) / 2];
        i = lo;
        j = hi;
        while (i <= j) begin
          while (i <= hi && line_order(order_mem[i], piv) < 0) i++;
          while (j >= lo && line_order(order_mem[j], piv) > 0) j--;
          if (i <= j) begin
            t = order_mem[i];
            order_mem[i] = order_mem[j];
            order_mem[j] = t;
            i++;
            j--;
          end
        end
        if (lo < j && sp < LINES) begin
          span_lo[sp] = lo;
          span_hi[sp] = j;
          sp++;
        end
        if (i < hi && sp < LINES) begin
          span_lo[sp] = i;
          span_hi[sp] = hi;
          sp++;
        end
      end
    end
    is_sorted = 1;
  endfunction

  function automatic sorter_result_t predict_result(input logic [1:0] op,
      input logic [7:0] ch, input logic [7:0] rk, input logic [6:0] col);
    sorter_result_t r;
    int             ln;
    r.ch = '0;
    r.len = '0;
    if (op == tls_pkg::OP_APPEND || op == tls_pkg::OP_END) begin
      is_sorted = 0;
      if (loaded >= LINES) begin
        ovf_seen = 1;
      end else if (op == tls_pkg::OP_END || ch == tls_pkg::CH_LF) begin
        close_line();
      end else begin
        text_mem[loaded*LINE_LEN + fill_col] = ch;
        fill_col++;
        if (fill_col >= LINE_LEN - 1) close_line();
      end
    end else if (op == tls_pkg::OP_SORT) begin
      if (fill_col > 0 && loaded < LINES) close_line();
      quicksort_lines();
    end
    r.st = ovf_seen ? tls_pkg::STAT_OVF : tls_pkg::STAT_OK;
    if (op == tls_pkg::OP_READ) begin
      if (!is_sorted || rk >= loaded) begin
        r.st = tls_pkg::STAT_BAD;
      end else begin
        ln = order_mem[rk];
        r.len = 7'(len_mem[ln]);
        if (col < len_mem[ln]) r.ch = text_mem[ln*LINE_LEN + col];
      end
    end
    r.cnt = 9'(loaded);
    return r;
  endfunction

  // result checker: values are stable at the falling edge, transfer at the next rise
  always @(negedge clk) begin
    sorter_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result transfer: status %0d", status);
      end else begin
        e = expected_q.pop_front();
        if (status !== e.st || char_out !== e.ch || line_length !== e.len ||
            line_count !== e.cnt) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp st %0d ch %0h len %0d cnt %0d, got %0d %0h %0d %0d",
                     e.st, e.ch, e.len, e.cnt, status, char_out, line_length, line_count);
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt <= hold_req;
      hold_req = 0;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(rx_pct > $urandom_range(99));
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      tls_pkg::REG_COLUMN_START:   cfg.column_start = val[7:0];
      tls_pkg::REG_CASE_SENSITIVE: cfg.case_sensitive = val[0];
      tls_pkg::REG_NUMERIC_KEYS:   cfg.numeric_keys = val[0];
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                           input logic [7:0] rk, input logic [6:0] col);
    int gap;
    gap = 0;
    while (tx_pct > $urandom_range(99)) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    expected_q.push_back(predict_result(op, ch, rk, col));
    in_valid <= 1'b1;
    operation <= op;
    char_in <= ch;
    rank <= rk;
    column <= col;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_keys(input logic [7:0] cs, input bit exact, input bit num);
    wait_drain();
    write_reg(tls_pkg::REG_COLUMN_START, {24'd0, cs});
    write_reg(tls_pkg::REG_CASE_SENSITIVE, {31'd0, exact});
    write_reg(tls_pkg::REG_NUMERIC_KEYS, {31'd0, num});
  endtask

  task automatic send_text(input string s, input bit by_end_op);
    for (int i = 0; i < s.len(); i++)
      send_item(tls_pkg::OP_APPEND, s[i], any_byte(), any_col());
    if (by_end_op) send_item(tls_pkg::OP_END, any_byte(), any_byte(), any_col());
    else send_item(tls_pkg::OP_APPEND, tls_pkg::CH_LF, any_byte(), any_col());
  endtask

  task automatic send_read(input int rk, input int col);
    send_item(tls_pkg::OP_READ, any_byte(), rk[7:0], col[6:0]);
  endtask

  function automatic logic [7:0] rand_char();
    case ($urandom_range(9))
      0, 1, 2: return 8'("a" + $urandom_range(3));
      3:       return 8'("A" + $urandom_range(3));
      4, 5:    return 8'(tls_pkg::CH_0 + $urandom_range(9));
      6:       return $urandom_range(1) ? tls_pkg::CH_SPACE : tls_pkg::CH_TAB;
      7:       return $urandom_range(1) ? tls_pkg::CH_MINUS : tls_pkg::CH_PLUS;
      default: return any_byte();
    endcase
  endfunction

  task automatic test_read_unsorted();
    send_read(0, 0);
    send_item(tls_pkg::OP_SORT, any_byte(), any_byte(), any_col());
    send_read(0, 0);
  endtask

  task automatic test_text_order();
    send_text("banana", 0);
    send_text("Apple", 1);
    send_text("apple", 0);
    send_item(tls_pkg::OP_APPEND, 8'hC8, 8'hFF, 7'h7F);   // negative as a signed byte
    send_item(tls_pkg::OP_APPEND, 8'h00, 8'h00, 7'h00);   // zero byte cuts the line short
    send_item(tls_pkg::OP_APPEND, "q", 8'h00, 7'h00);
    send_item(tls_pkg::OP_END, 8'hFF, 8'hFF, 7'h7F);
    send_item(tls_pkg::OP_END, 8'h00, 8'h00, 7'h00);      // empty line
    send_text("zz", 0);
    send_item(tls_pkg::OP_APPEND, "Z", 8'h00, 7'h00);     // left pending, closed by sort
    send_item(tls_pkg::OP_SORT, 8'hFF, 8'hFF, 7'h7F);
    for (int r = 0; r < 7; r++) send_read(r, r % 3);
    send_read(0, 127);
    send_read(255, 0);
  endtask

  task automatic test_numeric_keys();
    set_keys(8'd0, 1'b0, 1'b1);
    send_text("  -12", 0);
    send_text("+7", 1);
    send_text("\t5x", 0);
    send_text("2147483648", 0);          // wraps to the most negative value
    send_item(tls_pkg::OP_SORT, any_byte(), any_byte(), any_col());
    for (int r = 0; r < 8; r++) send_read(r, 0);
    set_keys(8'd128, 1'b1, 1'b0);        // key start past every line
    send_item(tls_pkg::OP_SORT, any_byte(), any_byte(), any_col());
    for (int r = 0; r < 4; r++) send_read(r, 1);
  endtask

  task automatic run_random(input int n_items, input int tx, input int rx);
    int sent, n, pick;
    sent = 0;
    tx_pct = tx;
    rx_pct = rx;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(120, 135) : $urandom_range(8);
        for (int i = 0; i < n; i++)
          send_item(tls_pkg::OP_APPEND, rand_char(), any_byte(), any_col());
        if ($urandom_range(1)) send_item(tls_pkg::OP_END, any_byte(), any_byte(), any_col());
        else send_item(tls_pkg::OP_APPEND, tls_pkg::CH_LF, any_byte(), any_col());
        sent += n + 1;
      end else if (pick < 63) begin
        send_item(tls_pkg::OP_SORT, any_byte(), any_byte(), any_col());
        sent++;
      end else if (pick < 68) begin
        send_item(any_op(), any_byte(), any_byte(), any_col());
        sent++;
      end else begin
        n = $urandom_range(2, 8);
        for (int i = 0; i < n; i++) begin
          if (loaded > 0 && $urandom_range(4) != 0)
            send_read($urandom_range(loaded - 1),
                      $urandom_range(1) ? $urandom_range(9) : $urandom_range(127));
          else
            send_read($urandom, $urandom);
        end
        sent += n;
      end
    end
  endtask

  task automatic test_random_keys();
    set_keys(8'd0, 1'b0, 1'b0);
    run_random(15, 0, 0);
    set_keys(8'd1, 1'b1, 1'b0);
    run_random(15, 75, 0);
    set_keys(8'd2, 1'b0, 1'b1);
    run_random(15, 0, 75);
    set_keys(8'd255, 1'b1, 1'b1);
    run_random(15, 9, 9);
    set_keys(8'($urandom_range(4)), 1'($urandom_range(1)), 1'b0);
    run_random(15, 30, 30);
    set_keys(8'd0, 1'b1, 1'b0);
    run_random(15, 0, 0);
  endtask

  task automatic test_backpressure();
    tx_pct = 0;
    rx_pct = 0;
    send_item(tls_pkg::OP_SORT, any_byte(), any_byte(), any_col());
    wait_drain();
    hold_req = 400;
    for (int i = 0; i < 24; i++) send_read($urandom_range(loaded - 1), $urandom_range(15));
    wait_drain();
  endtask

  task automatic test_line_overflow();
    set_keys(8'd0, 1'b0, 1'b0);
    tx_pct = 0;
    rx_pct = 0;
    while (loaded < LINES) send_item(tls_pkg::OP_END, any_byte(), any_byte(), any_col());
    send_item(tls_pkg::OP_APPEND, "x", any_byte(), any_col());
    send_item(tls_pkg::OP_END, any_byte(), any_byte(), any_col());
    send_item(tls_pkg::OP_SORT, any_byte(), any_byte(), any_col());
    send_read(255, 0);
    send_read(0, 127);
    for (int i = 0; i < 10; i++) send_read($urandom, $urandom);
  endtask

  initial begin
    cfg = '0;
    loaded = 0;
    fill_col = 0;
    ovf_seen = 0;
    is_sorted = 0;
    tx_pct = 0;
    rx_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_keys(8'd0, 1'b0, 1'b0);
    test_read_unsorted();
    test_text_order();
    test_numeric_keys();
    test_random_keys();
    test_backpressure();
    test_line_overflow();
    wait_drain();
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
